/* hdl/cfs_pkg.sv */
// shared types, constants and helpers of the cyclic correlation flip scorer
`timescale 1ns / 1ps

package cfs_pkg;

	localparam int MAX_CYCLE_DEF = 128;
	localparam logic [6:0] ORDER_RESET = 7'd32;
	localparam int CNT_W = 8;
	localparam int BND_W = 12;
	localparam int EX_W = 10;
	localparam int SQ_W = 27;
	localparam int LIN_W = 18;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [BND_W-1:0] bound_t;
	typedef logic [EX_W-1:0] ex_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ACC,
		ST_SCORE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// per-cell control
	typedef struct packed {
		logic load;
		logic rot;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic u;
		logic v;
		logic x;
	} cell_bits_t;

	typedef struct packed {
		cnt_t cu;
		cnt_t cv;
		cnt_t cx;
	} cell_acc_t;

	// bits seen by every cell from the head cell
	typedef struct packed {
		logic u;
		logic v;
		logic x;
	} bcast_t;

	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic [LIN_W-1:0] lin;
		cnt_t me_u;
		cnt_t me_v;
		cnt_t me_x;
		ex_t mx_u;
		ex_t mx_v;
		ex_t mx_x;
	} score_t;

	// count minus bound, floored at zero
	function automatic ex_t excess(input cnt_t cnt, input bound_t bound);
		bound_t diff;
		diff = $signed({{(BND_W-CNT_W){1'b0}}, cnt}) - bound;
		if (diff < 0) begin
			return '0;
		end
		return diff[EX_W-1:0];
	endfunction

endpackage

/* hdl/cfs_cell.sv */
// one lag cell: rotating vector bits and three correlation accumulators
`timescale 1ns / 1ps

module cfs_cell import cfs_pkg::*; (
	input  logic       clk,
	input  cell_ctl_t  ctl,
	input  bcast_t     head,
	input  cell_bits_t load_bits,
	input  cell_bits_t left_bits,
	input  cell_bits_t right_bits,
	input  logic       xp_right,
	input  cell_acc_t  right_acc,
	output cell_bits_t bits,
	output logic       xp,
	output cell_acc_t  acc
);

	cell_bits_t bits_q;
	logic xp_q;
	cell_acc_t acc_q;

	// load, rotate while accumulating, or shift toward the head for scoring
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bits_q <= load_bits;
			xp_q <= load_bits.x;
			acc_q <= '0;
		end else if (ctl.rot) begin
			bits_q <= left_bits;
			xp_q <= xp_right;
			acc_q.cu <= acc_q.cu + cnt_t'(head.u & bits_q.u) + cnt_t'(head.x & xp_q);
			acc_q.cv <= acc_q.cv + cnt_t'(head.v & bits_q.v) + cnt_t'(head.x & xp_q);
			acc_q.cx <= acc_q.cx + cnt_t'(head.u & bits_q.x) + cnt_t'(head.x & bits_q.v);
		end else if (ctl.shift) begin
			bits_q <= right_bits;
			acc_q <= right_acc;
		end
	end

	assign bits = bits_q;
	assign xp = xp_q;
	assign acc = acc_q;

endmodule

/* hdl/cfs_score.sv */
// per-lag scoring pipeline: excess, square, running sums and maxima
`timescale 1ns / 1ps

module cfs_score import cfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       valid,
	input  logic       en_uv,
	input  cell_acc_t  cnt,
	input  cell_bits_t edge_bits,
	input  bound_t     bnd_edge,
	input  bound_t     abs_u,
	input  bound_t     abs_v,
	input  bound_t     abs_x,
	output score_t     score
);

	logic valid_s1, valid_s2;
	ex_t ex_u_s1, ex_v_s1, ex_x_s1;
	cnt_t cu_s1, cv_s1, cx_s1;
	logic eu_s1, ev_s1, ex_edge_s1;
	logic [2*EX_W-1:0] sq_u_s2, sq_v_s2, sq_x_s2;
	score_t acc_q;

	// control valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: excess per channel
	always_ff @(posedge clk) begin
		ex_u_s1 <= en_uv ? excess(cnt.cu, edge_bits.u ? bnd_edge : abs_u) : '0;
		ex_v_s1 <= en_uv ? excess(cnt.cv, edge_bits.v ? bnd_edge : abs_v) : '0;
		ex_x_s1 <= excess(cnt.cx, edge_bits.x ? bnd_edge : abs_x);
		cu_s1 <= cnt.cu;
		cv_s1 <= cnt.cv;
		cx_s1 <= cnt.cx;
		eu_s1 <= en_uv & edge_bits.u;
		ev_s1 <= en_uv & edge_bits.v;
		ex_edge_s1 <= edge_bits.x;
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		sq_u_s2 <= (2*EX_W)'(ex_u_s1) * (2*EX_W)'(ex_u_s1);
		sq_v_s2 <= (2*EX_W)'(ex_v_s1) * (2*EX_W)'(ex_v_s1);
		sq_x_s2 <= (2*EX_W)'(ex_x_s1) * (2*EX_W)'(ex_x_s1);
	end

	// running sums and maxima
	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else begin
			if (valid_s1) begin
				acc_q.lin <= acc_q.lin + LIN_W'(ex_u_s1) + LIN_W'(ex_v_s1) + LIN_W'(ex_x_s1);
				if (ex_u_s1 > acc_q.mx_u) acc_q.mx_u <= ex_u_s1;
				if (ex_v_s1 > acc_q.mx_v) acc_q.mx_v <= ex_v_s1;
				if (ex_x_s1 > acc_q.mx_x) acc_q.mx_x <= ex_x_s1;
				if (eu_s1 && cu_s1 > acc_q.me_u) acc_q.me_u <= cu_s1;
				if (ev_s1 && cv_s1 > acc_q.me_v) acc_q.me_v <= cv_s1;
				if (ex_edge_s1 && cx_s1 > acc_q.me_x) acc_q.me_x <= cx_s1;
			end
			if (valid_s2) begin
				acc_q.sq <= acc_q.sq + SQ_W'(sq_u_s2) + SQ_W'(sq_v_s2) + SQ_W'(sq_x_s2);
			end
		end
	end

	assign score = acc_q;

endmodule

/* hdl/cyclic_correlation_flip_scorer.sv */
// top level of the cyclic correlation flip scorer
`timescale 1ns / 1ps

// Each item flips one variable and returns the full score of the new state.
// An item passes through these steps: the sequencer takes it and flips, loads the
// row of k = 2n-1 lag cells, rotates the vectors through the cells while every
// cell accumulates its own lag's three counts, then shifts the counts out through
// the head cell into the scoring pipeline, drains it and moves the result into
// the output register. One item is in work at a time; a finished result waits in
// the output register while the next item is taken, and the sequencer holds its
// next result until that register is free. Writing order_n clears all vectors;
// it is taken only while no item is in work and wins over an input item offered
// in the same cycle.
module cyclic_correlation_flip_scorer import cfs_pkg::*; #(
	parameter int MAX_CYCLE = MAX_CYCLE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,      // order_n
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // flip_index
	output logic         m_tvalid,
	input  logic         m_tready,
	// penalty_sq, penalty_linear, degree_u, degree_v, max_edge_count_u,
	// max_edge_count_v, max_edge_count_cross, excess_max_u, excess_max_v,
	// excess_max_cross
	output logic [111:0] m_tdata,
	output logic [0:0]   m_tuser        // bad_index
);

	localparam int CW = $clog2(MAX_CYCLE);
	localparam int XW = (CW + 3 > 9) ? CW + 3 : 9;
	localparam logic [XW-1:0] HALF_X = XW'(MAX_CYCLE / 2);

	state_t state_q, state_n;
	logic [6:0] order_q;
	logic [MAX_CYCLE-1:0] u_q, v_q, x_q;
	logic [CW-1:0] cnt_q, su_q, sv_q, sx_q;
	logic bad_q;
	logic [111:0] tdata_q;
	logic tuser_q, tvalid_q;

	logic [XW-1:0] ord_x, n_x, k_x, h_x, vars_x, idx_x, d_x, kd_x;
	logic [CW-1:0] k_c, k_m1;
	logic bad, in_acc, cnt_last, out_load, sc_clear, sc_valid;
	cell_ctl_t ctl;
	bcast_t head;
	cell_bits_t bits [MAX_CYCLE];
	logic xp [MAX_CYCLE];
	cell_acc_t acc [MAX_CYCLE];
	logic [CW:0] deg_u, deg_v;
	bound_t bnd_edge, abs_u, abs_v, abs_x;
	score_t score;

	// effective order and derived sizes
	always_comb begin
		ord_x = XW'(order_q);
		if (ord_x < XW'(2)) n_x = XW'(2);
		else if (ord_x > HALF_X) n_x = HALF_X;
		else n_x = ord_x;
		k_x = (n_x << 1) - XW'(1);
		h_x = n_x - XW'(1);
		vars_x = (h_x << 1) + k_x;
		k_c = k_x[CW-1:0];
		k_m1 = k_c - CW'(1);
		idx_x = XW'(s_tdata);
		bad = idx_x >= vars_x;
		if (idx_x < h_x) d_x = idx_x + XW'(1);
		else if (idx_x < (h_x << 1)) d_x = idx_x - h_x + XW'(1);
		else d_x = idx_x - (h_x << 1);
		kd_x = k_x - d_x;
	end

	assign in_acc = s_tvalid && s_tready;
	assign cnt_last = cnt_q == k_m1;
	assign cfg_ready = state_q == ST_IDLE;

	// order register and master vectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
			u_q <= '0;
			v_q <= '0;
			x_q <= '0;
			bad_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
			u_q <= '0;
			v_q <= '0;
			x_q <= '0;
		end else if (in_acc) begin
			bad_q <= bad;
			if (!bad) begin
				for (int i = 0; i < MAX_CYCLE; i++) begin
					if (idx_x < h_x) begin
						if (XW'(i) == d_x || XW'(i) == kd_x) u_q[i] <= ~u_q[i];
					end else if (idx_x < (h_x << 1)) begin
						if (XW'(i) == d_x || XW'(i) == kd_x) v_q[i] <= ~v_q[i];
					end else begin
						if (XW'(i) == d_x) x_q[i] <= ~x_q[i];
					end
				end
			end
		end
	end

	// sequencer state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_LOAD) cnt_q <= '0;
			else if (state_q == ST_ACC || state_q == ST_SCORE) cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
			else if (state_q == ST_DRAIN) cnt_q <= cnt_q + CW'(1);
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_n = ST_LOAD;
			ST_LOAD:  state_n = ST_ACC;
			ST_ACC:   if (cnt_last) state_n = ST_SCORE;
			ST_SCORE: if (cnt_last) state_n = ST_DRAIN;
			ST_DRAIN: if (cnt_q == CW'(1)) state_n = ST_DONE;
			ST_DONE:  if (out_load) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		s_tready = 1'b0;
		sc_clear = 1'b0;
		sc_valid = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = !cfg_valid;
			ST_LOAD: begin
				ctl.load = 1'b1;
				sc_clear = 1'b1;
			end
			ST_ACC:   ctl.rot = 1'b1;
			ST_SCORE: begin
				ctl.shift = 1'b1;
				sc_valid = 1'b1;
			end
			ST_DONE:  out_load = !tvalid_q || m_tready;
			default: ;
		endcase
	end

	// degree counters, fed by the head cell while rotating
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			su_q <= '0;
			sv_q <= '0;
			sx_q <= '0;
		end else if (ctl.rot) begin
			su_q <= su_q + CW'(bits[0].u);
			sv_q <= sv_q + CW'(bits[0].v);
			sx_q <= sx_q + CW'(xp[0]);
		end
	end

	assign head.u = bits[0].u;
	assign head.v = bits[0].v;
	assign head.x = xp[0];

	// row of lag cells
	for (genvar i = 0; i < MAX_CYCLE; i++) begin : g_cell
		cell_bits_t lb, ld, rb;
		cell_acc_t ra;
		logic xr;
		assign ld.u = u_q[i];
		assign ld.v = v_q[i];
		assign ld.x = x_q[i];
		if (i == 0) begin : g_first
			assign lb = bits[k_m1];
		end else begin : g_mid
			assign lb = bits[i-1];
		end
		if (i == MAX_CYCLE - 1) begin : g_last
			assign rb = '0;
			assign ra = '0;
			assign xr = xp[0];
		end else begin : g_inner
			assign rb = bits[i+1];
			assign ra = acc[i+1];
			assign xr = (CW'(i) == k_m1) ? xp[0] : xp[i+1];
		end
		cfs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.head       (head),
			.load_bits  (ld),
			.left_bits  (lb),
			.right_bits (rb),
			.xp_right   (xr),
			.right_acc  (ra),
			.bits       (bits[i]),
			.xp         (xp[i]),
			.acc        (acc[i])
		);
	end

	// bounds from degrees
	always_comb begin
		deg_u = (CW+1)'(su_q) + (CW+1)'(sx_q);
		deg_v = (CW+1)'(sv_q) + (CW+1)'(sx_q);
		bnd_edge = bound_t'(n_x) - bound_t'(2);
		abs_u = (bound_t'(deg_u) <<< 1) - bound_t'(3) * bound_t'(n_x) + bound_t'(3);
		abs_v = (bound_t'(deg_v) <<< 1) - bound_t'(3) * bound_t'(n_x) + bound_t'(3);
		abs_x = bound_t'(deg_u) + bound_t'(deg_v) - bound_t'(3) * bound_t'(n_x) + bound_t'(3);
	end

	cfs_score u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (sc_clear),
		.valid      (sc_valid),
		.en_uv      (cnt_q != '0),
		.cnt        (acc[0]),
		.edge_bits  (bits[0]),
		.bnd_edge   (bnd_edge),
		.abs_u      (abs_u),
		.abs_v      (abs_v),
		.abs_x      (abs_x),
		.score      (score)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_load) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tdata_q <= {score.mx_x[8:0], score.mx_v[8:0], score.mx_u[8:0],
				score.me_x, score.me_v, score.me_u, deg_v[7:0], deg_u[7:0],
				score.lin, score.sq};
			tuser_q <= bad_q;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

endmodule

/* tb/sv/cfs_score_checker.sv */
// checker for the flip scorer: tracks the vectors, predicts each score and compares
`timescale 1ns / 1ps

module cfs_score_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [6:0]   cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending_scores
);

	typedef struct packed {
		logic [26:0] sq;
		logic [17:0] lin;
		logic [7:0]  deg_u;
		logic [7:0]  deg_v;
		logic [7:0]  me_u;
		logic [7:0]  me_v;
		logic [7:0]  me_x;
		logic [8:0]  mx_u;
		logic [8:0]  mx_v;
		logic [8:0]  mx_x;
		logic        bad;
	} score_rec_t;

	logic [6:0] order_reg;
	logic u_vec [128];
	logic v_vec [128];
	logic x_vec [128];
	score_rec_t score_q[$];

	function automatic int ex_of(int cnt, int bnd);
		return (cnt > bnd) ? cnt - bnd : 0;
	endfunction

	// apply one flip and score the resulting state
	function automatic score_rec_t flip_and_score(logic [7:0] idx);
		score_rec_t r;
		int n, k, h, d, w, su, sv, sx, du, dv, cu, cv, cx, e, bu, bv, bx;
		int sq, lin, meu, mev, mex, mxu, mxv, mxx;
		int cuarr [128];
		int cvarr [128];
		int cxarr [128];
		n = order_reg;
		if (n < 2) n = 2;
		if (n > 64) n = 64;
		k = 2 * n - 1;
		h = n - 1;
		r = '0;
		r.bad = (idx >= 2 * h + k);
		if (!r.bad) begin
			if (idx < h) begin
				d = idx + 1;
				u_vec[d] = !u_vec[d];
				u_vec[k-d] = u_vec[d];
			end else if (idx < 2 * h) begin
				d = idx - h + 1;
				v_vec[d] = !v_vec[d];
				v_vec[k-d] = v_vec[d];
			end else begin
				x_vec[idx-2*h] = !x_vec[idx-2*h];
			end
		end
		for (d = 0; d < k; d++) begin
			cu = 0; cv = 0; cx = 0;
			for (w = 0; w < k; w++) begin
				cu += (u_vec[w] & u_vec[(w+k-d)%k]) + (x_vec[w] & x_vec[(w+k-d)%k]);
				cv += (v_vec[w] & v_vec[(w+k-d)%k]) + (x_vec[w] & x_vec[(w+d)%k]);
				cx += (u_vec[w] & x_vec[(d+k-w)%k]) + (x_vec[w] & v_vec[(w+k-d)%k]);
			end
			cuarr[d] = cu & 8'hff;
			cvarr[d] = cv & 8'hff;
			cxarr[d] = cx & 8'hff;
		end
		su = 0; sv = 0; sx = 0;
		for (d = 0; d < k; d++) begin
			su += u_vec[d];
			sv += v_vec[d];
			sx += x_vec[d];
		end
		du = su + sx;
		dv = sv + sx;
		bu = 2 * du - 3 * n + 3;
		bv = 2 * dv - 3 * n + 3;
		bx = du + dv - 3 * n + 3;
		sq = 0; lin = 0; meu = 0; mev = 0; mex = 0; mxu = 0; mxv = 0; mxx = 0;
		for (d = 0; d < k; d++) begin
			if (d > 0) begin
				e = ex_of(cuarr[d], u_vec[d] ? n - 2 : bu);
				sq += e * e; lin += e;
				if (e > mxu) mxu = e;
				if (u_vec[d] && cuarr[d] > meu) meu = cuarr[d];
				e = ex_of(cvarr[d], v_vec[d] ? n - 2 : bv);
				sq += e * e; lin += e;
				if (e > mxv) mxv = e;
				if (v_vec[d] && cvarr[d] > mev) mev = cvarr[d];
			end
			e = ex_of(cxarr[d], x_vec[d] ? n - 2 : bx);
			sq += e * e; lin += e;
			if (e > mxx) mxx = e;
			if (x_vec[d] && cxarr[d] > mex) mex = cxarr[d];
		end
		r.sq = 27'(sq); r.lin = 18'(lin); r.deg_u = 8'(du); r.deg_v = 8'(dv);
		r.me_u = 8'(meu); r.me_v = 8'(mev); r.me_x = 8'(mex);
		r.mx_u = 9'(mxu); r.mx_v = 9'(mxv); r.mx_x = 9'(mxx);
		return r;
	endfunction

	// track config writes and flips, compare results
	always @(posedge clk or negedge arst_n) begin
		score_rec_t want, got;
		if (!arst_n) begin
			order_reg <= 7'd32;
			for (int i = 0; i < 128; i++) begin
				u_vec[i] = 0; v_vec[i] = 0; x_vec[i] = 0;
			end
			score_q.delete();
			fail_count <= 0;
			pending_scores <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_reg <= cfg_data;
				for (int i = 0; i < 128; i++) begin
					u_vec[i] = 0; v_vec[i] = 0; x_vec[i] = 0;
				end
			end
			if (s_tvalid && s_tready) begin
				score_q.push_back(flip_and_score(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[26:0], m_tdata[44:27], m_tdata[52:45], m_tdata[60:53],
					m_tdata[68:61], m_tdata[76:69], m_tdata[84:77], m_tdata[93:85],
					m_tdata[102:94], m_tdata[111:103], m_tuser[0]};
				if (score_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected score item %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = score_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display({"score mismatch: exp sq=%0d lin=%0d du=%0d dv=%0d",
								" me=%0d/%0d/%0d mx=%0d/%0d/%0d bad=%0d"},
								want.sq, want.lin, want.deg_u, want.deg_v, want.me_u,
								want.me_v, want.me_x, want.mx_u, want.mx_v, want.mx_x,
								want.bad);
							$display({"                got sq=%0d lin=%0d du=%0d dv=%0d",
								" me=%0d/%0d/%0d mx=%0d/%0d/%0d bad=%0d"},
								got.sq, got.lin, got.deg_u, got.deg_v, got.me_u,
								got.me_v, got.me_x, got.mx_u, got.mx_v, got.mx_x,
								got.bad);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_scores <= score_q.size();
		end
	end

endmodule

/* tb/sv/tb_cyclic_correlation_flip_scorer.sv */
// testbench top: drives flips and order writes into the scorer and reports the verdict
`timescale 1ns / 1ps

module tb_cyclic_correlation_flip_scorer;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [6:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;       // flip_index
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;       // penalty_sq up to excess_max_cross
	logic [0:0]   m_tuser;       // bad_index
	int           fail_count;
	int           pending_scores;
	int           hold_cycles;
	logic [6:0]   cur_order;

	cyclic_correlation_flip_scorer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	cfs_score_checker score_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending_scores(pending_scores)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// send one flip and wait until it is taken; valid stays up for a following item
	task automatic send_flip(logic [7:0] idx);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= idx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering items and wait until every expected result has come
	task automatic wait_idle();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_scores != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_order(logic [6:0] val);
		cfg_valid <= 1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		cur_order = val;
	endtask

	// random flip biased to valid indices for the current order
	function automatic logic [7:0] rand_flip();
		int n;
		n = cur_order < 2 ? 2 : (cur_order > 64 ? 64 : cur_order);
		if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 4 * n - 4));
	endfunction

	// receiver: random stalls, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (hold_cycles > 0) begin
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	initial begin
		logic [6:0] orders [8];
		orders = '{7'd2, 7'd3, 7'd64, 7'd0, 7'd127, 7'd5, 7'd9, 7'd17};
		hold_cycles = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cur_order = 7'd32;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed at reset order: field extremes and every kind of flip
		send_flip(8'd0);
		send_flip(8'd30);
		send_flip(8'd31);
		send_flip(8'd62);
		send_flip(8'd124);
		send_flip(8'd125);
		send_flip(8'd255);
		send_flip(8'd0);
		send_flip(8'd62);
		send_flip(8'd100);
		// long receiver hold while flips keep coming
		fork
			begin
				hold_cycles = 1;
				repeat (2000) @(posedge clk);
				hold_cycles = 0;
			end
			begin
				for (int i = 0; i < 6; i++) send_flip(rand_flip());
				s_tvalid <= 0;
			end
		join
		wait_idle();
		// random phases over several orders, extremes among them
		for (int p = 0; p < 8; p++) begin
			write_order(orders[p]);
			for (int i = 0; i < 228; i++) begin
				if (i == 100) wait_idle();
				send_flip(rand_flip());
			end
			wait_idle();
		end
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
